[design/lcs_pkg.sv]
// lcs_pkg: shared sizes, types and helpers for the lru cache set unit
// no dependencies; imported by lcs_lookup, lru_cache_set_unit, its checker and its testbench
package lcs_pkg;

  localparam int MAX_WAYS = 8;
  localparam int TAG_BITS = 32;
  localparam int WAY_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_BITS = $clog2(MAX_WAYS + 1);
  localparam int CFG_BITS = 4;
  localparam int PORT_TAG_BITS = 32;

  typedef logic [WAY_BITS-1:0] way_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [CFG_BITS-1:0] cfg_t;
  typedef way_t [MAX_WAYS-1:0] order_t;
  typedef tag_t [MAX_WAYS-1:0] tag_array_t;

  // outcome of one lookup against the current set contents
  typedef struct packed {
    logic hit;
    logic evict;
    way_t pos;
    way_t way;
  } lookup_t;

  // register value 0 acts as 1, values above the way count saturate
  function automatic cnt_t effective_ways(cfg_t w);
    cnt_t r;
    if (w == '0) begin
      r = cnt_t'(1);
    end else if (int'(w) > MAX_WAYS) begin
      r = cnt_t'(MAX_WAYS);
    end else begin
      r = cnt_t'(w);
    end
    return r;
  endfunction

  function automatic order_t identity_order();
    order_t o;
    for (int i = 0; i < MAX_WAYS; i++) begin
      o[i] = way_t'(i);
    end
    return o;
  endfunction

endpackage

[design/lcs_lookup.sv]
// lcs_lookup: tag compare across the valid ways and choice of the position to promote
// depends on lcs_pkg
module lcs_lookup (
  input  lcs_pkg::tag_t       tag,
  input  lcs_pkg::tag_array_t tags,
  input  lcs_pkg::order_t     order,
  input  lcs_pkg::cnt_t       fill,
  input  lcs_pkg::cnt_t       limit,
  output lcs_pkg::lookup_t    result
);
  import lcs_pkg::*;

  logic [MAX_WAYS-1:0] pos_match;
  way_t                match_pos;
  cnt_t                last_pos;

  always_comb begin
    for (int p = 0; p < MAX_WAYS; p++) begin
      pos_match[p] = (cnt_t'(p) < fill) && (tags[order[p]] == tag);
    end
  end

  // valid tags are unique, lowest position wins anyway
  always_comb begin
    match_pos = '0;
    for (int p = MAX_WAYS - 1; p >= 0; p--) begin
      if (pos_match[p]) begin
        match_pos = way_t'(p);
      end
    end
  end

  assign last_pos = fill - cnt_t'(1);

  always_comb begin
    result.hit   = |pos_match;
    result.evict = 1'b0;
    if (result.hit) begin
      result.pos = match_pos;
    end else if (fill < limit) begin
      // first free way sits just past the valid ones
      result.pos = way_t'(fill);
    end else begin
      result.pos   = way_t'(last_pos);
      result.evict = 1'b1;
    end
    result.way = order[result.pos];
  end

endmodule

[design/lru_cache_set_unit.sv]
// lru_cache_set_unit: one set of a set-associative cache with true lru replacement
// depends on lcs_pkg and lcs_lookup
//
// Takes one access per clock: busy stays low, so an access is transferred at every
// edge where start is high. The tag is captured in an input register; in the next
// cycle the lookup against the stored ways and the recency update run through one
// level of compare and select logic, and the result is loaded into the output
// register at the next edge. Done is registered from the pending flag and is high
// for a single cycle as that result appears. The recency state is written at the
// edge that loads the output register, so back-to-back accesses see each other's
// effect. The receiver cannot stall: each result is present for exactly one cycle.
// A configuration transfer (cfg_ready is always high) sets the associativity and
// empties the set; issue it only when no access is in flight.
module lru_cache_set_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 access_tag,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lcs_pkg::CFG_BITS-1:0] cfg_data,
  output logic                        done,
  output logic                        hit,
  output logic                        evicted_valid,
  output logic [31:0]                 evicted_tag
);
  import lcs_pkg::*;

  cfg_t       ways_in_use;
  cnt_t       limit;
  cnt_t       fill;
  order_t     order;
  order_t     order_next;
  tag_array_t tags;
  tag_t       tag_q;
  logic       pend;
  lookup_t    look;
  logic       accept;
  logic       cfg_write;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign limit     = effective_ways(ways_in_use);

  lcs_lookup u_lookup (
    .tag    (tag_q),
    .tags   (tags),
    .order  (order),
    .fill   (fill),
    .limit  (limit),
    .result (look)
  );

  // move the chosen position to the front, shifting the more recent ones down
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i == 0) begin
        order_next[i] = order[look.pos];
      end else if (way_t'(i) <= look.pos) begin
        order_next[i] = order[i-1];
      end else begin
        order_next[i] = order[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= cfg_t'(1);
      order       <= identity_order();
      fill        <= '0;
      pend        <= 1'b0;
      done        <= 1'b0;
    end else begin
      pend <= accept;
      done <= pend;
      if (cfg_write) begin
        ways_in_use <= cfg_data;
        order       <= identity_order();
        fill        <= '0;
      end else if (pend) begin
        order <= order_next;
        if (!look.hit && !look.evict) begin
          fill <= fill + cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q <= tag_t'(access_tag);
    end
    if (pend) begin
      hit           <= look.hit;
      evicted_valid <= look.evict;
      evicted_tag   <= look.evict ? PORT_TAG_BITS'(tags[look.way]) : '0;
      if (!look.hit) begin
        tags[look.way] <= tag_q;
      end
    end
  end

  a_fill_limit: assert property (@(posedge clk) disable iff (rst) fill <= limit)
    else $error("fill count above associativity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst) accept |=> ##1 done)
    else $error("accepted access produced no result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without an accepted access");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (pend && look.evict) |-> (fill == limit) && !look.hit)
    else $error("eviction from a set that is not full");

endmodule

[tb/sv/lru_cache_set_unit_chk.sv]
// lru_cache_set_unit_chk: watches the access, configuration and result channels
// of lru_cache_set_unit, predicts each outcome and compares it; depends on lcs_pkg
module lru_cache_set_unit_chk (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [31:0]              access_tag,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [lcs_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                     done,
  input  logic                     hit,
  input  logic                     evicted_valid,
  input  logic [31:0]              evicted_tag,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lcs_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [31:0] evicted_tag;
  } access_outcome_t;

  tag_t            set_tags [MAX_WAYS];
  way_t            lru_order [MAX_WAYS];
  int              valid_ways;
  cfg_t            assoc_reg;
  access_outcome_t outcome_q [$];

  function automatic int assoc_limit(cfg_t w);
    int n;
    n = int'(w);
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_WAYS) begin
      n = MAX_WAYS;
    end
    return n;
  endfunction

  task automatic clear_set();
    for (int i = 0; i < MAX_WAYS; i++) begin
      lru_order[i] = way_t'(i);
    end
    valid_ways = 0;
  endtask

  // move the way at position pos to the front, shifting the newer ones back
  task automatic make_mru(int pos);
    way_t w;
    w = lru_order[pos];
    for (int i = pos; i > 0; i--) begin
      lru_order[i] = lru_order[i-1];
    end
    lru_order[0] = w;
  endtask

  task automatic apply_access(input tag_t t, output access_outcome_t r);
    int hit_pos;
    int last;
    hit_pos = -1;
    r = '0;
    for (int p = 0; p < valid_ways; p++) begin
      if (hit_pos < 0 && set_tags[lru_order[p]] == t) begin
        hit_pos = p;
      end
    end
    if (hit_pos >= 0) begin
      make_mru(hit_pos);
      r.hit = 1'b1;
    end else if (valid_ways < assoc_limit(assoc_reg)) begin
      set_tags[lru_order[valid_ways]] = t;
      make_mru(valid_ways);
      valid_ways++;
    end else begin
      last = valid_ways - 1;
      r.evicted_valid = 1'b1;
      r.evicted_tag = 32'(set_tags[lru_order[last]]);
      set_tags[lru_order[last]] = t;
      make_mru(last);
    end
  endtask

  always @(posedge clk) begin
    access_outcome_t exp_r;
    access_outcome_t got_r;
    if (rst) begin
      errors = 0;
      assoc_reg = cfg_t'(1);
      clear_set();
      outcome_q.delete();
    end else begin
      if (done) begin
        got_r = '{hit: hit, evicted_valid: evicted_valid, evicted_tag: evicted_tag};
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: hit=%0b ev=%0b tag=%h",
                   $time, hit, evicted_valid, evicted_tag);
          errors++;
        end else begin
          exp_r = outcome_q.pop_front();
          if (got_r.hit !== exp_r.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, got_r.hit);
            errors++;
          end
          if (got_r.evicted_valid !== exp_r.evicted_valid) begin
            $display("%0t: evicted_valid expected %0b actual %0b", $time,
                     exp_r.evicted_valid, got_r.evicted_valid);
            errors++;
          end
          if (got_r.evicted_tag !== exp_r.evicted_tag) begin
            $display("%0t: evicted_tag expected %h actual %h", $time,
                     exp_r.evicted_tag, got_r.evicted_tag);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        apply_access(tag_t'(access_tag), exp_r);
        outcome_q.push_back(exp_r);
      end
      if (cfg_valid && cfg_ready) begin
        assoc_reg = cfg_data;
        clear_set();
      end
    end
    pending = outcome_q.size();
  end

endmodule

[tb/sv/lru_cache_set_unit_tb.sv]
// lru_cache_set_unit_tb: drives accesses and associativity writes into
// lru_cache_set_unit and reports the verdict; depends on lcs_pkg and the checker
module lru_cache_set_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] access_tag;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_t        cfg_data;
  logic        done;
  logic        hit;
  logic        evicted_valid;
  logic [31:0] evicted_tag;
  int          errors;
  int          pending;
  int          cycle_count = 0;

  lru_cache_set_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .access_tag(access_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .hit(hit), .evicted_valid(evicted_valid), .evicted_tag(evicted_tag)
  );

  lru_cache_set_unit_chk chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .access_tag(access_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .hit(hit), .evicted_valid(evicted_valid), .evicted_tag(evicted_tag),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lru_cache_set_unit_tb: done, errors");
      $finish;
    end
  end

  // one access transfer, then maybe an idle gap on the sender side
  task automatic issue(input logic [31:0] t, input int idle_pct);
    start <= 1'b1;
    access_tag <= t;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // sample the outstanding count away from the clock edge
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_assoc(input cfg_t v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  cfg_t phase_assoc [18] = '{4'd8, 4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                             4'd8, 4'd9, 4'd15, 4'd0, 4'd4, 4'd4, 4'd12, 4'd3, 4'd8};
  int    phase_idle [4] = '{0, 45, 0, 38};

  initial begin
    logic [31:0] tag_pool [12];
    int          pool_size;
    start = 1'b0;
    access_tag = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset associativity of one: fill, hit, evict both ways round
    issue(32'h0000_0000, 0);
    issue(32'h0000_0000, 0);
    issue(32'hffff_ffff, 0);
    issue(32'hffff_ffff, 0);
    issue(32'h0000_0000, 0);

    // full eight-way set, touch the oldest, then evict the next oldest
    set_assoc(cfg_t'(8));
    for (int i = 0; i < 8; i++) begin
      issue(32'h1 << i, 0);
    end
    issue(32'h0000_0001, 0);
    issue(32'ha5a5_a5a5, 0);

    // register zero acts as one way
    set_assoc(cfg_t'(0));
    issue(32'h1234_5678, 0);
    issue(32'h1234_5678, 0);
    issue(32'hedcb_a987, 0);

    // register above the way count saturates
    set_assoc(cfg_t'(15));
    issue(32'hffff_ffff, 0);
    issue(32'h0000_0000, 0);

    for (int ph = 0; ph < 18; ph++) begin
      // rewriting the same value still empties the set
      set_assoc(phase_assoc[ph]);
      pool_size = $urandom_range(2, 11);
      for (int k = 0; k < 12; k++) begin
        tag_pool[k] = $urandom();
      end
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(99) < 80) begin
          issue(tag_pool[$urandom_range(pool_size - 1)], phase_idle[ph % 4]);
        end else begin
          issue($urandom(), phase_idle[ph % 4]);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("lru_cache_set_unit_tb: done, clean");
    end else begin
      $display("lru_cache_set_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lcs_pkg.sv
design/lcs_lookup.sv
design/lru_cache_set_unit.sv
tb/sv/lru_cache_set_unit_chk.sv
tb/sv/lru_cache_set_unit_tb.sv
